### src/lcp_pkg.sv
package lcp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Field limits
  localparam logic [35:0] LIMIT_SHORT = 36'h0_0000_FFFF;
  localparam logic [35:0] LIMIT_LONG  = 36'h0_FFFF_FFFF;

  // Line length default
  localparam int MAX_LINE_LENGTH_DEF = 64;

  // Configuration register indexes
  localparam logic [1:0] REG_INVALID_TARGET = 2'd0;
  localparam logic [1:0] REG_MAX_TYPE       = 2'd1;
  localparam logic [1:0] REG_SOURCE_ID      = 2'd2;

  // Field position within a line
  typedef enum logic [1:0] {
    FLD_TARGET = 2'd0,
    FLD_TYPE   = 2'd1,
    FLD_ARG    = 2'd2,
    FLD_DONE   = 2'd3
  } field_t;

  // Payload widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 144;

endpackage

### src/line_command_parser_core.sv
// A newline transfer shows its result on out_* in the next cycle.
// Takes one byte per cycle while in_tready is high; the per-byte parse step is one
//   multiply-by-ten add and compare between the state and result registers.
// Input stalls only while a result waits in the output register and out_tready is low.
// Reset (rst_n low, synchronous) clears the parse state, the error count and
//   the output valid, and loads the register defaults 0, 3 and 1.
module line_command_parser_core
  import lcp_pkg::*;
#(
  parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: data_byte[7:0], now_ms[39:8]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: target_id[15:0], command_type[31:16], argument_value[63:32],
  //   received_at[95:64], origin_id[111:96], error_total[143:112]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: parse_ok[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [15:0]           cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_LINE_LENGTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LINE_LENGTH - 1);

  // Configuration registers
  logic [15:0] invalid_target_r, max_type_r, source_id_r;

  // Parse state
  logic [CNT_W-1:0] line_count_r, line_count_nxt;
  logic             discarding_r, discarding_nxt;
  field_t           field_r, field_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             seen_r, seen_nxt;
  logic             failed_r, failed_nxt;
  logic [15:0]      held_target_r, held_target_nxt;
  logic [15:0]      held_type_r, held_type_nxt;
  logic [31:0]      err_cnt_r, err_cnt_nxt;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_ok_r;

  logic        in_xfer;
  logic [7:0]  c;
  logic [31:0] now;
  logic        emit, ok;
  logic [35:0] prod, limit;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign c          = in_tdata[7:0];
  assign now        = in_tdata[39:8];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  // Decimal accumulate: acc * 10 + digit
  assign prod  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {28'd0, c - CHAR_ZERO};
  assign limit = (field_r == FLD_ARG) ? LIMIT_LONG : LIMIT_SHORT;
  assign ok    = !failed_r && (field_r == FLD_DONE || (field_r == FLD_ARG && seen_r));

  // Next parse state for the incoming byte
  always_comb begin
    line_count_nxt  = line_count_r;
    discarding_nxt  = discarding_r;
    field_nxt       = field_r;
    acc_nxt         = acc_r;
    seen_nxt        = seen_r;
    failed_nxt      = failed_r;
    held_target_nxt = held_target_r;
    held_type_nxt   = held_type_r;
    err_cnt_nxt     = err_cnt_r;
    emit            = 1'b0;
    if (c == CHAR_CR) begin
      // ignore carriage return
    end else if (c == CHAR_LF) begin
      if (!discarding_r && line_count_r != '0) begin
        emit = 1'b1;
        if (!ok) err_cnt_nxt = err_cnt_r + 32'd1;
      end
      discarding_nxt  = 1'b0;
      line_count_nxt  = '0;
      field_nxt       = FLD_TARGET;
      acc_nxt         = '0;
      seen_nxt        = 1'b0;
      failed_nxt      = 1'b0;
      held_target_nxt = '0;
      held_type_nxt   = '0;
    end else if (discarding_r) begin
      // drop the rest of an overlong line
    end else if (line_count_r >= CNT_LAST) begin
      err_cnt_nxt     = err_cnt_r + 32'd1;
      discarding_nxt  = 1'b1;
      line_count_nxt  = '0;
      field_nxt       = FLD_TARGET;
      acc_nxt         = '0;
      seen_nxt        = 1'b0;
      failed_nxt      = 1'b0;
      held_target_nxt = '0;
      held_type_nxt   = '0;
    end else begin
      line_count_nxt = line_count_r + CNT_W'(1);
      if (!failed_r && field_r != FLD_DONE) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          if (prod > limit) begin
            failed_nxt = 1'b1;
          end else begin
            acc_nxt  = prod[31:0];
            seen_nxt = 1'b1;
          end
        end else if (c == CHAR_NUL) begin
          if (field_r == FLD_ARG && seen_r) field_nxt = FLD_DONE;
          else failed_nxt = 1'b1;
        end else if (c == CHAR_SEMI && field_r != FLD_ARG && seen_r) begin
          if (field_r == FLD_TARGET) begin
            if (acc_r == {16'd0, invalid_target_r}) begin
              failed_nxt = 1'b1;
            end else begin
              held_target_nxt = acc_r[15:0];
              field_nxt       = FLD_TYPE;
              acc_nxt         = '0;
              seen_nxt        = 1'b0;
            end
          end else begin
            if (acc_r > {16'd0, max_type_r}) begin
              failed_nxt = 1'b1;
            end else begin
              held_type_nxt = acc_r[15:0];
              field_nxt     = FLD_ARG;
              acc_nxt       = '0;
              seen_nxt      = 1'b0;
            end
          end
        end else begin
          failed_nxt = 1'b1;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_target_r <= 16'd0;
      max_type_r       <= 16'd3;
      source_id_r      <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INVALID_TARGET: invalid_target_r <= cfg_wdata;
        REG_MAX_TYPE:       max_type_r       <= cfg_wdata;
        REG_SOURCE_ID:      source_id_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance parse state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r  <= '0;
      discarding_r  <= 1'b0;
      field_r       <= FLD_TARGET;
      acc_r         <= '0;
      seen_r        <= 1'b0;
      failed_r      <= 1'b0;
      held_target_r <= '0;
      held_type_r   <= '0;
      err_cnt_r     <= '0;
    end else if (in_xfer) begin
      line_count_r  <= line_count_nxt;
      discarding_r  <= discarding_nxt;
      field_r       <= field_nxt;
      acc_r         <= acc_nxt;
      seen_r        <= seen_nxt;
      failed_r      <= failed_nxt;
      held_target_r <= held_target_nxt;
      held_type_r   <= held_type_nxt;
      err_cnt_r     <= err_cnt_nxt;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_ok_r   <= ok;
      out_data_r <= {err_cnt_nxt, source_id_r, now,
                     ok ? acc_r : 32'd0,
                     ok ? held_type_r : 16'd0,
                     ok ? held_target_r : 16'd0};
    end
  end

endmodule

### src/line_command_parser_core_checker.sv
module lcp_checker
  import lcp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // Output drops after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A rejected line carries zero command fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[63:0] == 64'd0)
    else $error("rejected line with nonzero fields");

  // A new result follows only a newline transfer
  a_from_newline: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tdata[7:0] == CHAR_LF))
    else $error("result without newline");

  // Input is open whenever the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind line_command_parser_core lcp_checker u_lcp_checker (.*);
